FILE: hw/rtl/packed_date_to_epoch_seconds_unit_assert.svh
// assertion macros shared by the date conversion rtl
`ifndef PACKED_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define PACKED_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PDES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdes assertion failed");

// next-cycle implication, checked out of reset
`define PDES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdes assertion failed");

`endif

FILE: hw/rtl/pdes_pkg.sv
// constants and tables for the packed date to epoch seconds unit
package pdes_pkg;

  localparam int unsigned NumStages = 9;

  localparam logic [16:0] EpochYear     = 17'd1970;
  localparam logic [16:0] LeapBaseYear  = 17'd1968;
  localparam logic [16:0] CenturyBase   = 17'd1900;
  localparam logic [16:0] QuadCentBase  = 17'd1600;

  // floor(x / 100) = (x * Recip100) >> Recip100Shift for any 16-bit x
  localparam logic [18:0] Recip100      = 19'd335545;
  localparam int unsigned Recip100Shift = 25;
  // floor(x / 12) for x below 1024
  localparam logic [9:0]  Recip12       = 10'd683;
  localparam int unsigned Recip12Shift  = 13;
  // floor(x / 25) for x below 4096
  localparam logic [12:0] Recip25       = 13'd5243;
  localparam int unsigned Recip25Shift  = 17;

  localparam logic [8:0]  DaysPerYear   = 9'd365;
  localparam logic [11:0] SecsPerHour   = 12'd3600;
  localparam logic [5:0]  SecsPerMinute = 6'd60;

  localparam logic signed [41:0] SecsPerDay     = 42'sd86400;
  localparam logic signed [41:0] ValidFromSecs  = 42'sd1483228800;
  localparam logic [31:0]        BadPartNumber  = 32'd124097;

  // days in the year before the first of each month, non-leap
  function automatic logic [8:0] days_before_month(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/pdes_req_if.sv
// request channel: packed date words and part number
interface pdes_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] year_word;
  logic [15:0] month_day_word;
  logic [15:0] hour_minute_word;
  logic [31:0] part_number;

  modport source (
    output valid, year_word, month_day_word, hour_minute_word, part_number,
    input  ready
  );
  modport sink (
    input  valid, year_word, month_day_word, hour_minute_word, part_number,
    output ready
  );
endinterface

FILE: hw/rtl/pdes_rsp_if.sv
// response channel: epoch seconds and status flags
interface pdes_rsp_if;
  logic        valid;
  logic        ready;
  logic [40:0] epoch_seconds;
  logic        date_ok;
  logic        data_valid;

  modport source (
    output valid, epoch_seconds, date_ok, data_valid,
    input  ready
  );
  modport sink (
    input  valid, epoch_seconds, date_ok, data_valid,
    output ready
  );
endinterface

FILE: hw/rtl/packed_date_to_epoch_seconds_unit.sv
// packed decimal build date to unix seconds, nine stage pipeline
//
// usage:
//   req_i carries one request: year word, month*100+day word, hour*100+minute
//   word and a 32-bit part number. rsp_o returns one result per request:
//   epoch_seconds (seconds since 1970-01-01 utc), date_ok and data_valid.
//   both channels use valid/ready; a request or result moves on a clock edge
//   with valid and ready high.
// throughput:
//   a request loads into the first of the nine stages at the accepting edge.
//   one request per cycle is taken while no result is stalled on rsp_o; the
//   rate is set by the single pipeline enable, every stage moves together.
// stalls:
//   while a result waits on rsp_o with ready low, the whole pipeline holds and
//   req_i.ready is low; nothing is dropped or repeated. bubbles stay in place.
// reset:
//   rst_ni low clears all stage valid bits at once; data registers are not
//   reset. req_i.ready is high in the first cycle after reset.
// bad dates:
//   month zero or a carried year before 1970 gives zero seconds and clears both
//   flags; a time before the epoch saturates to zero with date_ok still set.
`include "packed_date_to_epoch_seconds_unit_assert.svh"

module packed_date_to_epoch_seconds_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdes_req_if.sink   req_i,
  pdes_rsp_if.source rsp_o
);

  // ---------------------------------------------------------------------------
  // pipeline control: one enable for every stage
  // ---------------------------------------------------------------------------
  logic       pipe_en;
  logic [7:0] vld_q;       // valid bits of stages one to eight
  logic       out_vld_q;   // output register holds a result

  assign pipe_en     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[6:0], req_i.valid};
      out_vld_q <= vld_q[7];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: month and hour by reciprocal multiply, part number check
  // ---------------------------------------------------------------------------
  logic [34:0] s1_month_prod, s1_hour_prod;
  logic [15:0] s1_yw_q, s1_md_q, s1_hm_q;
  logic [9:0]  s1_month_q, s1_hour_q;
  logic        s1_pn_ok_q;

  assign s1_month_prod = 35'(req_i.month_day_word) * 35'(pdes_pkg::Recip100);
  assign s1_hour_prod  = 35'(req_i.hour_minute_word) * 35'(pdes_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_yw_q    <= req_i.year_word;
      s1_md_q    <= req_i.month_day_word;
      s1_hm_q    <= req_i.hour_minute_word;
      s1_month_q <= s1_month_prod[pdes_pkg::Recip100Shift +: 10];
      s1_hour_q  <= s1_hour_prod[pdes_pkg::Recip100Shift +: 10];
      s1_pn_ok_q <= req_i.part_number != pdes_pkg::BadPartNumber;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: day and minute remainders, years carried by month overflow
  // ---------------------------------------------------------------------------
  logic [15:0] s2_md_rem, s2_hm_rem;
  logic [9:0]  s2_mm1;
  logic [19:0] s2_q12_prod;
  logic [15:0] s2_yw_q;
  logic [6:0]  s2_mday_q, s2_minute_q;
  logic [9:0]  s2_hour_q, s2_mm1_q;
  logic [5:0]  s2_q12_q;
  logic        s2_month_ok_q, s2_pn_ok_q;

  assign s2_md_rem   = s1_md_q - 16'(s1_month_q) * 16'd100;
  assign s2_hm_rem   = s1_hm_q - 16'(s1_hour_q) * 16'd100;
  assign s2_mm1      = s1_month_q - 10'd1;
  assign s2_q12_prod = 20'(s2_mm1) * 20'(pdes_pkg::Recip12);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_yw_q       <= s1_yw_q;
      s2_mday_q     <= s2_md_rem[6:0];
      s2_minute_q   <= s2_hm_rem[6:0];
      s2_hour_q     <= s1_hour_q;
      s2_mm1_q      <= s2_mm1;
      s2_q12_q      <= s2_q12_prod[pdes_pkg::Recip12Shift +: 6];
      s2_month_ok_q <= s1_month_q != 10'd0;
      s2_pn_ok_q    <= s1_pn_ok_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: carried year, month index, time of day parts in seconds
  // ---------------------------------------------------------------------------
  logic [9:0]  s3_mi_full;
  logic [16:0] s3_year_q;
  logic [3:0]  s3_mi_q;
  logic [21:0] s3_hsec_q;
  logic [12:0] s3_msec_q;
  logic [6:0]  s3_mday_q;
  logic        s3_month_ok_q, s3_pn_ok_q;

  assign s3_mi_full = s2_mm1_q - 10'(s2_q12_q) * 10'd12;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_year_q     <= 17'(s2_yw_q) + 17'(s2_q12_q);
      s3_mi_q       <= s3_mi_full[3:0];
      s3_hsec_q     <= 22'(s2_hour_q) * 22'(pdes_pkg::SecsPerHour);
      s3_msec_q     <= 13'(s2_minute_q) * 13'(pdes_pkg::SecsPerMinute);
      s3_mday_q     <= s2_mday_q;
      s3_month_ok_q <= s2_month_ok_q;
      s3_pn_ok_q    <= s2_pn_ok_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: year terms of the gregorian day count
  // ---------------------------------------------------------------------------
  logic [16:0] s4_ym, s4_y68, s4_y19, s4_y16;
  logic [34:0] s4_q100_prod;
  logic [24:0] s4_q400_prod;
  logic [24:0] s4_ym365_q;
  logic [13:0] s4_d4_q;
  logic [15:0] s4_y19_q;
  logic [9:0]  s4_q100_q;
  logic [7:0]  s4_q400_q;
  logic        s4_yr4_q, s4_ok_q, s4_pn_ok_q;
  logic [3:0]  s4_mi_q;
  logic [6:0]  s4_mday_q;
  logic [21:0] s4_hmsec_q;

  assign s4_ym  = s3_year_q - pdes_pkg::EpochYear;
  assign s4_y68 = s3_year_q - pdes_pkg::LeapBaseYear;
  assign s4_y19 = s3_year_q - pdes_pkg::CenturyBase;
  assign s4_y16 = s3_year_q - pdes_pkg::QuadCentBase;
  // values are junk below 1970; such items are flagged not ok and zeroed
  assign s4_q100_prod = 35'(s4_y19[15:0]) * 35'(pdes_pkg::Recip100);
  assign s4_q400_prod = 25'(s4_y16[15:4]) * 25'(pdes_pkg::Recip25);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_ym365_q <= 25'(s4_ym[15:0]) * 25'(pdes_pkg::DaysPerYear);
      s4_d4_q    <= s4_y68[15:2];
      s4_y19_q   <= s4_y19[15:0];
      s4_q100_q  <= s4_q100_prod[pdes_pkg::Recip100Shift +: 10];
      s4_q400_q  <= s4_q400_prod[pdes_pkg::Recip25Shift +: 8];
      s4_yr4_q   <= s3_year_q[1:0] == 2'd0;
      s4_ok_q    <= s3_month_ok_q && (s3_year_q >= pdes_pkg::EpochYear);
      s4_pn_ok_q <= s3_pn_ok_q;
      s4_mi_q    <= s3_mi_q;
      s4_mday_q  <= s3_mday_q;
      s4_hmsec_q <= s3_hsec_q + 22'(s3_msec_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: leap test and partial day sums
  // ---------------------------------------------------------------------------
  logic        s5_z100, s5_leap;
  logic [24:0] s5_a_q;
  logic [8:0]  s5_b_q;
  logic        s5_adj_q, s5_ok_q, s5_pn_ok_q;
  logic [21:0] s5_hmsec_q;

  // year divisible by 100; by 400 when (year / 100) is a multiple of four,
  // i.e. (year - 1900) / 100 leaves one modulo four
  assign s5_z100 = s4_y19_q == 16'(s4_q100_q) * 16'd100;
  assign s5_leap = s4_yr4_q && (!s5_z100 || (s4_q100_q[1:0] == 2'd1));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_a_q     <= s4_ym365_q + 25'(s4_d4_q) - 25'(s4_q100_q) + 25'(s4_q400_q);
      s5_b_q     <= pdes_pkg::days_before_month(s4_mi_q) + 9'(s4_mday_q);
      s5_adj_q   <= s5_leap && (s4_mi_q < 4'd2);
      s5_ok_q    <= s4_ok_q;
      s5_pn_ok_q <= s4_pn_ok_q;
      s5_hmsec_q <= s4_hmsec_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: day count since the epoch (can be minus one)
  // ---------------------------------------------------------------------------
  logic signed [25:0] s6_days_q;
  logic               s6_ok_q, s6_pn_ok_q;
  logic [21:0]        s6_hmsec_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_days_q  <= $signed({1'b0, s5_a_q}) + $signed({17'b0, s5_b_q})
                    - 26'sd1 - $signed({25'b0, s5_adj_q});
      s6_ok_q    <= s5_ok_q;
      s6_pn_ok_q <= s5_pn_ok_q;
      s6_hmsec_q <= s5_hmsec_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: days to seconds
  // ---------------------------------------------------------------------------
  logic signed [41:0] s7_prod_q;
  logic               s7_ok_q, s7_pn_ok_q;
  logic [21:0]        s7_hmsec_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s7_prod_q  <= 42'(s6_days_q) * pdes_pkg::SecsPerDay;
      s7_ok_q    <= s6_ok_q;
      s7_pn_ok_q <= s6_pn_ok_q;
      s7_hmsec_q <= s6_hmsec_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: add time of day
  // ---------------------------------------------------------------------------
  logic signed [41:0] s8_t_q;
  logic               s8_ok_q, s8_pn_ok_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s8_t_q     <= s7_prod_q + $signed({20'b0, s7_hmsec_q});
      s8_ok_q    <= s7_ok_q;
      s8_pn_ok_q <= s7_pn_ok_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: saturate at the epoch, flags, output register
  // ---------------------------------------------------------------------------
  logic [40:0] out_secs_q;
  logic        out_date_ok_q, out_data_valid_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_secs_q       <= (s8_ok_q && (s8_t_q > 42'sd0)) ? s8_t_q[40:0] : '0;
      out_date_ok_q    <= s8_ok_q;
      out_data_valid_q <= s8_ok_q && s8_pn_ok_q && (s8_t_q >= pdes_pkg::ValidFromSecs);
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.epoch_seconds = out_secs_q;
  assign rsp_o.date_ok       = out_date_ok_q;
  assign rsp_o.data_valid    = out_data_valid_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PDES_ASSERT_IMP(a_bad_date_zero, out_vld_q && !out_date_ok_q,
                   (out_secs_q == '0) && !out_data_valid_q)
  `PDES_ASSERT_IMP(a_valid_implies_ok, out_vld_q && out_data_valid_q,
                   out_date_ok_q && (out_secs_q >= 41'd1483228800))
  `PDES_ASSERT_NXT(a_stall_holds_pipe, !pipe_en, $stable(vld_q) && out_vld_q)
  `PDES_ASSERT_IMP(a_empty_out_ready, !out_vld_q, req_i.ready)

endmodule

FILE: bench/pdes_epoch_monitor.sv
// watches both channels, predicts epoch seconds and flags, and compares results
module pdes_epoch_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  pdes_req_if  req_i,
  pdes_rsp_if  rsp_i,
  output int   mismatches_o,
  output int   outstanding_o
);

  localparam int unsigned UnixBaseYear = 1970;
  localparam longint SecsPerDay = 86400;
  localparam longint FirstTrustedSecs = 64'sd1483228800;
  localparam logic [31:0] PlaceholderPart = 32'd124097;

  // month lengths of a common year, january at index 0
  localparam logic [11:0][4:0] MonthLen = {
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
  };

  typedef struct packed {
    logic [40:0] secs;
    logic        ok;
    logic        trusted;
  } epoch_result_t;

  epoch_result_t expected_q[$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  function automatic epoch_result_t date_words_to_epoch(
    input logic [15:0] yw,
    input logic [15:0] md,
    input logic [15:0] hm,
    input logic [31:0] pn
  );
    int unsigned   month;
    int unsigned   mday;
    int unsigned   hour;
    int unsigned   minute;
    int unsigned   mi;
    int unsigned   year;
    longint        days;
    longint        t;
    epoch_result_t r;
    r      = '0;
    month  = md / 100;
    mday   = md % 100;
    hour   = hm / 100;
    minute = hm % 100;
    if (month >= 1) begin
      mi   = (month - 1) % 12;
      year = yw + (month - 1) / 12;
      if (year >= UnixBaseYear) begin
        r.ok = 1'b1;
        days = longint'(year - UnixBaseYear) * 365
             + longint'((year - 1968) / 4)
             - longint'((year - 1900) / 100)
             + longint'((year - 1600) / 400);
        for (int k = 0; k < 12; k++) begin
          if (k < mi) days += longint'(MonthLen[k]);
        end
        // leap day not yet reached in january and february
        if ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0)) && (mi < 2))
          days -= 1;
        days += longint'(mday) - 1;
        t = days * SecsPerDay + longint'(hour) * 3600 + longint'(minute) * 60;
        if (t > 0) r.secs = t[40:0];
        r.trusted = (t >= FirstTrustedSecs) && (pn != PlaceholderPart);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [40:0] got,
                                 input logic [40:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i) begin
    epoch_result_t want;
    logic          popped;
    logic          pushed;
    popped = 1'b0;
    pushed = 1'b0;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_i.epoch_seconds, '0);
        end else begin
          want   = expected_q.pop_front();
          popped = 1'b1;
          if (rsp_i.epoch_seconds !== want.secs)
            report_mismatch("epoch_seconds", rsp_i.epoch_seconds, want.secs);
          if (rsp_i.date_ok !== want.ok)
            report_mismatch("date_ok", 41'(rsp_i.date_ok), 41'(want.ok));
          if (rsp_i.data_valid !== want.trusted)
            report_mismatch("data_valid", 41'(rsp_i.data_valid), 41'(want.trusted));
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(date_words_to_epoch(req_i.year_word, req_i.month_day_word,
                                                 req_i.hour_minute_word, req_i.part_number));
        pushed = 1'b1;
      end
    end
    outstanding_o <= outstanding_o + int'(pushed) - int'(popped);
  end

endmodule

FILE: bench/packed_date_to_epoch_seconds_unit_test.sv
// top of the date conversion bench: stimulus, handshake pacing and verdict
module packed_date_to_epoch_seconds_unit_test;

  // random requests after the directed corner cases
  localparam int unsigned RandomRequests = 1930;
  // cycles without any handshake before the run is declared hung; the worst
  // legal quiet stretch is the long output hold plus pipeline refill
  localparam int unsigned StallLimit     = 2000;
  // quiet cycles after the last result so a stray extra result still shows
  localparam int unsigned DrainCycles    = 30;
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned BurstRequests  = 60;
  localparam int unsigned HoldAtRequest  = 600;
  localparam int unsigned PauseAtRequest = 1200;
  localparam logic [31:0] PlaceholderPart = 32'd124097;

  typedef struct packed {
    logic [15:0] yw;
    logic [15:0] md;
    logic [15:0] hm;
    logic [31:0] pn;
  } date_req_t;

  logic        clk_i;
  logic        rst_ni;
  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left = 0;

  pdes_req_if req_if ();
  pdes_rsp_if rsp_if ();

  packed_date_to_epoch_seconds_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pdes_epoch_monitor epoch_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one request: optional idle gap, then hold valid until the block takes it
  task automatic offer_date(input date_req_t r);
    int unsigned gap;
    // flip into or out of a gap-free stretch now and then
    if ($urandom_range(99, 0) == 0) sender_calm = !sender_calm;
    gap = (sender_calm || burst_left != 0) ? 0 : $urandom_range(6, 0);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.year_word        <= r.yw;
    req_if.month_day_word   <= r.md;
    req_if.hour_minute_word <= r.hm;
    req_if.part_number      <= r.pn;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic offer_words(input logic [15:0] yw, input logic [15:0] md,
                             input logic [15:0] hm, input logic [31:0] pn);
    date_req_t r;
    r = '{yw: yw, md: md, hm: hm, pn: pn};
    offer_date(r);
  endtask

  // mostly plausible dates with random content, plus raw noise and
  // requests clustered around the epoch and the 2017 trust boundary
  function automatic date_req_t random_date_request();
    date_req_t   r;
    int unsigned kind;
    int unsigned month;
    int unsigned day;
    int unsigned hour;
    int unsigned minute;
    kind = $urandom_range(9, 0);
    r.pn = $urandom;
    if ($urandom_range(15, 0) == 0) r.pn = PlaceholderPart;
    if (kind < 7) begin
      r.yw   = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 1970))
                                           : 16'($urandom_range(2110, 1960));
      month  = ($urandom_range(7, 0) == 0) ? $urandom_range(654, 0) : $urandom_range(12, 1);
      day    = ($urandom_range(7, 0) == 0) ? $urandom_range(99, 0) : $urandom_range(31, 1);
      hour   = ($urandom_range(7, 0) == 0) ? $urandom_range(654, 0) : $urandom_range(23, 0);
      minute = ($urandom_range(7, 0) == 0) ? $urandom_range(99, 0) : $urandom_range(59, 0);
      r.md   = 16'(month * 100 + day);
      r.hm   = 16'(hour * 100 + minute);
    end else if (kind < 9) begin
      r.yw = 16'($urandom);
      r.md = 16'($urandom);
      r.hm = 16'($urandom);
    end else begin
      r.yw   = ($urandom_range(1, 0) == 0) ? 16'($urandom_range(1971, 1969))
                                           : 16'($urandom_range(2017, 2016));
      month  = $urandom_range(1, 0) == 0 ? $urandom_range(1, 0) : $urandom_range(13, 12);
      day    = $urandom_range(1, 0) == 0 ? $urandom_range(1, 0) : 31;
      hour   = $urandom_range(1, 0) == 0 ? 0 : 23;
      minute = $urandom_range(1, 0) == 0 ? 0 : 59;
      r.md   = 16'(month * 100 + day);
      r.hm   = 16'(hour * 100 + minute);
    end
    return r;
  endfunction

  // result side: random back-pressure per result, one long hold on request
  initial begin
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        // keep ready low long enough for the pipeline to fill and stall req
        rsp_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(49, 0) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // hang detection: count cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // request side and verdict
  initial begin
    date_req_t r;
    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.year_word        <= '0;
    req_if.month_day_word   <= '0;
    req_if.hour_minute_word <= '0;
    req_if.part_number      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // month zero, all words zero
    offer_words(16'd0, 16'd0, 16'd0, 32'd0);
    // month zero with a sensible year (day 99 of month 0)
    offer_words(16'd2021, 16'd99, 16'd1200, 32'd5);
    // the epoch itself
    offer_words(16'd1970, 16'd101, 16'd0, 32'd1);
    // day zero of january 1970 lands before the epoch and saturates
    offer_words(16'd1970, 16'd100, 16'd0, 32'd1);
    offer_words(16'd1970, 16'd100, 16'd2359, 32'd1);
    // early year, and month 13 of 1969 carrying into january 1970
    offer_words(16'd1969, 16'd1201, 16'd0, 32'd1);
    offer_words(16'd1969, 16'd1301, 16'd0, 32'd1);
    // the trust boundary: last minute of 2016, first of 2017, bad part number
    offer_words(16'd2016, 16'd1231, 16'd2359, 32'd2);
    offer_words(16'd2017, 16'd101, 16'd0, 32'd2);
    offer_words(16'd2017, 16'd101, 16'd0, PlaceholderPart);
    // leap rule: 400-year leap, 100-year non-leap, ordinary leap
    offer_words(16'd2000, 16'd229, 16'd1200, 32'd3);
    offer_words(16'd2100, 16'd301, 16'd0, 32'd3);
    offer_words(16'd2024, 16'd229, 16'd2359, 32'd3);
    offer_words(16'd2400, 16'd229, 16'd30, 32'd3);
    // unchecked day, hour and minute used as plain offsets
    offer_words(16'd2021, 16'd1299, 16'd9999, 32'd4);
    // month carry far into the future and an early year after carry
    offer_words(16'd2020, 16'd65535, 16'd0, 32'd4);
    offer_words(16'd0, 16'd65535, 16'd0, 32'd4);
    // all inputs at their maximum, then the maximum year alone, then a 2038 date
    offer_words(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_words(16'hFFFF, 16'd101, 16'd0, 32'd0);
    offer_words(16'd2038, 16'd119, 16'd314, 32'h8000_0000);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == HoldAtRequest) begin
        // results blocked for a long stretch while requests keep coming
        long_hold_req = 1'b1;
        burst_left    = BurstRequests;
      end
      if (n == PauseAtRequest) begin
        // sender goes quiet until the pipeline has fully drained
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      r = random_date_request();
      offer_date(r);
      if (burst_left != 0) burst_left--;
    end
    req_if.valid <= 1'b0;

    // wait for every result, then a little longer for any stray one
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pdes_pkg.sv
hw/rtl/pdes_req_if.sv
hw/rtl/pdes_rsp_if.sv
hw/rtl/packed_date_to_epoch_seconds_unit.sv
bench/pdes_epoch_monitor.sv
bench/packed_date_to_epoch_seconds_unit_test.sv
